@@ hdl/pmbv_pkg.sv @@
// constants shared by the polyline miter border vertex core
// no dependencies; imported by polyline_miter_border_vertex_core
package pmbv_pkg;

  localparam int BW_W = 16;
  localparam logic [BW_W-1:0] BW_RESET = 16'd256;

  // edge magnitudes are scaled down below this many bits before the length step
  localparam int MAG_W = 24;
  localparam int LEN_SHIFT = 14;
  localparam int UNIT_SHIFT = 23;
  localparam int UNIT_QW = 17;
  localparam int ROOT_W = 32;

  localparam int SQRT_STEPS = 32;
  localparam int UDIV_STEPS = UNIT_QW;
  localparam int WDIV_STEPS = 36;
  localparam int DEN_W = 23;
  localparam int DEN_RND = 32768;

endpackage

@@ hdl/polyline_miter_border_vertex_core.sv @@
// polyline miter border vertex: pipelined unit vectors, bisector, miter scale
// depends on pmbv_pkg
//
//   channel    direction  contents
//   s_axis     in         tdata: prev_x, prev_y, curr_x, curr_y, next_x, next_y
//   m_axis     out        tdata: corner_x, corner_y, offset_x, offset_y; tuser: degenerate
//   cfg        in         cfg_wdata_i: border_width, written when cfg_we_i is high
//
// one word per cycle in and out while the output is not stalled; 100 pipeline stages plus
// the output register, most of them the 32 square root steps and the 17 and 36 step dividers
// reset clears all valid bits and sets border_width to 1.0
// a stalled output parks one word in a skid register; the pipeline holds only
// while that register is full
module polyline_miter_border_vertex_core #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pmbv_pkg::BW_W-1:0]            cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // prev_x, prev_y, curr_x, curr_y, next_x, next_y, zero padding
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // corner_x, corner_y, offset_x, offset_y, zero padding
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // degenerate
  output logic                                 m_axis_tuser
);
  import pmbv_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int OUT_W = ((4*CW+7)/8)*8;
  localparam int SHMAX = (CW > MAG_W) ? CW - MAG_W : 0;
  localparam int AW = ((CW > 37) ? CW : 37) + 1;
  localparam longint HI_L = (longint'(1) <<< (CW-1)) - 1;
  localparam longint LO_L = -HI_L - 1;

  localparam int ST_SIGN = 5 + SQRT_STEPS + 1 + UDIV_STEPS;
  localparam int ST_DOT = ST_SIGN + 3;
  localparam int ST_ADD = ST_DOT + 3 + WDIV_STEPS + 1;
  localparam int NST = ST_ADD + 2;
  localparam int REV_N = NST - ST_DOT;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 zero;
    logic [3:0]           sg;
  } side_t;

  logic [BW_W-1:0] bw_q;
  logic            en, accept;
  logic [NST-1:0]  vld_q;
  side_t           side_q [NST];
  side_t           side_d;
  logic [REV_N-1:0] rev_q;

  // stage 0 to 4
  logic signed [CW-1:0] in_px, in_py, in_cx, in_cy, in_nx, in_ny;
  logic signed [DW-1:0] dl_d [4];
  logic signed [DW-1:0] dl_q [4];
  logic [CW-1:0]        ab_q [4];
  logic [MAG_W-1:0]     sc_d [4];
  logic [MAG_W-1:0]     sc_q [4];
  logic [2*MAG_W-1:0]   sq_q [4];
  logic [MAG_W-1:0]     sq_m_q [4];

  // square root and unit division
  logic [63:0]          sr_n [0:SQRT_STEPS][0:1];
  logic [63:0]          sr_r [0:SQRT_STEPS][0:1];
  logic [MAG_W-1:0]     sr_m [0:SQRT_STEPS][0:3];
  logic [ROOT_W-1:0]    ud_rem [0:UDIV_STEPS][0:3];
  logic [UNIT_QW-1:0]   ud_low [0:UDIV_STEPS][0:3];
  logic [UNIT_QW-1:0]   ud_q [0:UDIV_STEPS][0:3];
  logic [ROOT_W-1:0]    ud_l [0:UDIV_STEPS][0:1];

  // bisector and miter
  logic signed [17:0]   un_q [4];
  logic signed [18:0]   sm_sx_q, sm_sy_q, sm_vx_q, sm_vy_q;
  logic signed [36:0]   pr_xv_q, pr_yv_q;
  logic signed [35:0]   pr_wsy_q, pr_wsx_q;
  logic [DEN_W-1:0]     dt_den_q;
  logic signed [35:0]   dt_w_q [2];
  logic [34:0]          mg_m_q [2];
  logic                 mg_s_q [2];
  logic [DEN_W-1:0]     mg_den_q;
  logic [DEN_W-1:0]     wd_rem [0:WDIV_STEPS][0:1];
  logic [35:0]          wd_low [0:WDIV_STEPS][0:1];
  logic [35:0]          wd_q [0:WDIV_STEPS][0:1];
  logic                 wd_s [0:WDIV_STEPS][0:1];
  logic [DEN_W-1:0]     wd_den [0:WDIV_STEPS];
  logic signed [36:0]   qs_q [2];
  logic signed [AW-1:0] ad_x_q, ad_y_q;
  logic signed [CW-1:0] st_x_q, st_y_q;

  // output side
  logic [OUT_W-1:0]     res_word;
  logic                 res_deg;
  logic signed [CW-1:0] res_ox, res_oy;
  logic [OUT_W-1:0]     out_q, skid_q;
  logic                 out_deg_q, skid_deg_q;
  logic                 out_vld_q, skid_vld_q;
  logic                 push;

  assign en            = ~skid_vld_q;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid & en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= BW_RESET;
    end else if (cfg_we_i) begin
      bw_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    in_px = $signed(s_axis_tdata[CW-1:0]);
    in_py = $signed(s_axis_tdata[2*CW-1:CW]);
    in_cx = $signed(s_axis_tdata[3*CW-1:2*CW]);
    in_cy = $signed(s_axis_tdata[4*CW-1:3*CW]);
    in_nx = $signed(s_axis_tdata[5*CW-1:4*CW]);
    in_ny = $signed(s_axis_tdata[6*CW-1:5*CW]);
    dl_d[0] = DW'(in_cx) - DW'(in_px);
    dl_d[1] = DW'(in_cy) - DW'(in_py);
    dl_d[2] = DW'(in_nx) - DW'(in_cx);
    dl_d[3] = DW'(in_ny) - DW'(in_cy);
    side_d.x    = in_cx;
    side_d.y    = in_cy;
    side_d.zero = ((dl_d[0] == '0) && (dl_d[1] == '0)) ||
                  ((dl_d[2] == '0) && (dl_d[3] == '0));
    for (int j = 0; j < 4; j++) begin
      side_d.sg[j] = dl_d[j][DW-1];
    end
  end

  // valid bits and side payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < NST; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // scale down long edges
  always_comb begin
    logic [CW-1:0] o;
    logic [5:0]    sh;
    for (int e = 0; e < 2; e++) begin
      o  = ab_q[2*e] | ab_q[2*e+1];
      sh = '0;
      for (int k = 0; k < SHMAX; k++) begin
        if (o[MAG_W+k]) begin
          sh = 6'(k + 1);
        end
      end
      sc_d[2*e]   = MAG_W'(ab_q[2*e] >> sh);
      sc_d[2*e+1] = MAG_W'(ab_q[2*e+1] >> sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        dl_q[j]   <= dl_d[j];
        ab_q[j]   <= dl_q[j][DW-1] ? CW'(-dl_q[j]) : CW'(dl_q[j]);
        sc_q[j]   <= sc_d[j];
        sq_q[j]   <= (2*MAG_W)'(sc_q[j]) * (2*MAG_W)'(sc_q[j]);
        sq_m_q[j] <= sc_q[j];
        sr_m[0][j] <= sq_m_q[j];
      end
      for (int e = 0; e < 2; e++) begin
        sr_n[0][e] <= 64'({(2*MAG_W+1)'(sq_q[2*e]) + (2*MAG_W+1)'(sq_q[2*e+1]),
                           LEN_SHIFT'(0)});
        sr_r[0][e] <= '0;
      end
    end
  end

  // edge length, one root bit per stage
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'(1) << (62 - 2*i);
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int e = 0; e < 2; e++) begin
          if (sr_n[i][e] >= sr_r[i][e] + BITV) begin
            sr_n[i+1][e] <= sr_n[i][e] - (sr_r[i][e] + BITV);
            sr_r[i+1][e] <= (sr_r[i][e] >> 1) + BITV;
          end else begin
            sr_n[i+1][e] <= sr_n[i][e];
            sr_r[i+1][e] <= sr_r[i][e] >> 1;
          end
        end
        for (int j = 0; j < 4; j++) begin
          sr_m[i+1][j] <= sr_m[i][j];
        end
      end
    end
  end

  // rounded numerator for the unit components
  always_ff @(posedge clk_i) begin
    logic [47:0] num;
    if (en) begin
      for (int e = 0; e < 2; e++) begin
        ud_l[0][e] <= sr_r[SQRT_STEPS][e][ROOT_W-1:0];
      end
      for (int j = 0; j < 4; j++) begin
        num = 48'({sr_m[SQRT_STEPS][j], UNIT_SHIFT'(0)}) +
              48'(sr_r[SQRT_STEPS][j/2][ROOT_W-1:0] >> 1);
        ud_rem[0][j] <= ROOT_W'(num[47:UNIT_QW]);
        ud_low[0][j] <= num[UNIT_QW-1:0];
        ud_q[0][j]   <= '0;
      end
    end
  end

  for (genvar i = 0; i < UDIV_STEPS; i++) begin : g_udiv
    always_ff @(posedge clk_i) begin
      logic [ROOT_W:0] t;
      logic            ge;
      if (en) begin
        for (int e = 0; e < 2; e++) begin
          ud_l[i+1][e] <= ud_l[i][e];
        end
        for (int j = 0; j < 4; j++) begin
          t  = {ud_rem[i][j], ud_low[i][j][UNIT_QW-1]};
          ge = t >= {1'b0, ud_l[i][j/2]};
          ud_rem[i+1][j] <= ge ? ROOT_W'(t - {1'b0, ud_l[i][j/2]}) : t[ROOT_W-1:0];
          ud_low[i+1][j] <= ud_low[i][j] << 1;
          ud_q[i+1][j]   <= {ud_q[i][j][UNIT_QW-2:0], ge};
        end
      end
    end
  end

  // signed units, bisector sum, dot product and scaled perpendicular
  always_ff @(posedge clk_i) begin
    logic signed [17:0] u;
    logic signed [37:0] dot;
    logic [38:0]        rnd;
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        u = $signed({1'b0, ud_q[UDIV_STEPS][j]});
        un_q[j] <= side_q[ST_SIGN-1].sg[j] ? -u : u;
      end
      sm_sx_q <= 19'(un_q[0]) + 19'(un_q[2]);
      sm_sy_q <= 19'(un_q[1]) + 19'(un_q[3]);
      sm_vx_q <= 19'(un_q[2]);
      sm_vy_q <= 19'(un_q[3]);
      pr_xv_q  <= 37'(sm_sx_q) * 37'(sm_vx_q);
      pr_yv_q  <= 37'(sm_sy_q) * 37'(sm_vy_q);
      pr_wsy_q <= 36'(sm_sy_q) * $signed(36'({1'b0, bw_q}));
      pr_wsx_q <= 36'(sm_sx_q) * $signed(36'({1'b0, bw_q}));
      dot = 38'(pr_xv_q) + 38'(pr_yv_q);
      rnd = 39'(dot) + 39'(DEN_RND);
      dt_den_q <= rnd[38:16];
      dt_w_q[0] <= pr_wsy_q;
      dt_w_q[1] <= pr_wsx_q;
      for (int l = 0; l < 2; l++) begin
        mg_m_q[l] <= dt_w_q[l][35] ? 35'(-dt_w_q[l]) : 35'(dt_w_q[l]);
        mg_s_q[l] <= dt_w_q[l][35];
        wd_low[0][l] <= 36'(mg_m_q[l]) + 36'(mg_den_q >> 1);
        wd_rem[0][l] <= '0;
        wd_q[0][l]   <= '0;
        wd_s[0][l]   <= mg_s_q[l];
      end
      mg_den_q  <= dt_den_q;
      wd_den[0] <= mg_den_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [37:0] dot;
    logic [38:0]        rnd;
    if (en) begin
      dot = 38'(pr_xv_q) + 38'(pr_yv_q);
      rnd = 39'(dot) + 39'(DEN_RND);
      rev_q <= {rev_q[REV_N-2:0], dot[37] || (dot == '0) || (rnd[38:16] == '0)};
    end
  end

  for (genvar i = 0; i < WDIV_STEPS; i++) begin : g_wdiv
    always_ff @(posedge clk_i) begin
      logic [DEN_W:0] t;
      logic           ge;
      if (en) begin
        wd_den[i+1] <= wd_den[i];
        for (int l = 0; l < 2; l++) begin
          t  = {wd_rem[i][l], wd_low[i][l][35]};
          ge = t >= {1'b0, wd_den[i]};
          wd_rem[i+1][l] <= ge ? DEN_W'(t - {1'b0, wd_den[i]}) : t[DEN_W-1:0];
          wd_low[i+1][l] <= wd_low[i][l] << 1;
          wd_q[i+1][l]   <= {wd_q[i][l][34:0], ge};
          wd_s[i+1][l]   <= wd_s[i][l];
        end
      end
    end
  end

  // apply offset and saturate
  always_ff @(posedge clk_i) begin
    logic signed [36:0] q;
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        q = $signed({1'b0, wd_q[WDIV_STEPS][l]});
        qs_q[l] <= wd_s[WDIV_STEPS][l] ? -q : q;
      end
      ad_x_q <= AW'(side_q[ST_ADD-1].x) - AW'(qs_q[0]);
      ad_y_q <= AW'(side_q[ST_ADD-1].y) + AW'(qs_q[1]);
      st_x_q <= (ad_x_q > AW'(HI_L)) ? CW'(HI_L) :
                (ad_x_q < AW'(LO_L)) ? CW'(LO_L) : CW'(ad_x_q);
      st_y_q <= (ad_y_q > AW'(HI_L)) ? CW'(HI_L) :
                (ad_y_q < AW'(LO_L)) ? CW'(LO_L) : CW'(ad_y_q);
    end
  end

  always_comb begin
    res_deg  = side_q[NST-1].zero | rev_q[REV_N-1];
    res_ox   = res_deg ? side_q[NST-1].x : st_x_q;
    res_oy   = res_deg ? side_q[NST-1].y : st_y_q;
    res_word = OUT_W'({res_oy, res_ox, side_q[NST-1].y, side_q[NST-1].x});
    push     = en & vld_q[NST-1];
  end

  // output register and skid word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      if (skid_vld_q) begin
        out_q     <= skid_q;
        out_deg_q <= skid_deg_q;
      end else begin
        out_q     <= res_word;
        out_deg_q <= res_deg;
      end
    end else if (push) begin
      skid_q     <= res_word;
      skid_deg_q <= res_deg;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_deg_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word held without an output word");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready && push) |=> skid_vld_q)
    else $error("word lost on stalled output");

  a_degen_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_deg_q) |->
      (out_q[3*CW-1:2*CW] == out_q[CW-1:0]) && (out_q[4*CW-1:3*CW] == out_q[2*CW-1:CW]))
    else $error("degenerate offset differs from corner");

endmodule
